[rtl/core/ssb_pkg.sv]
// ---------------------------------------------------------------------------
// ssb_pkg
// Shared types, constants and helpers of the sprite sheet blitter.
// ---------------------------------------------------------------------------
package ssb_pkg;

  // default geometry
  localparam int ScreenWidthDef   = 128;
  localparam int ScreenHeightDef  = 128;
  localparam int SpriteEdgeDef    = 8;
  localparam int SheetColumnsDef  = 16;
  localparam int SheetRowCountDef = 8;

  // sheet store: 128 bytes per row, 8192 bytes
  localparam int StoreDepth  = 8192;
  localparam int StoreAw     = 13;
  localparam int StrideShift = 7;
  localparam int ColorW      = 8;
  localparam int IdW         = 8;
  localparam int PosW        = 9;
  localparam int PixAddrW    = 14;
  // signed screen coordinate: 9-bit position plus an offset below 8
  localparam int CoordW      = 12;
  localparam int RemapLimit  = 16;

  // configuration port
  localparam int RegW  = 64;
  localparam int PaddrW = 4;
  localparam int RegSel = 3;
  localparam logic RegPalLow  = 1'b0;
  localparam logic RegPalHigh = 1'b1;
  localparam logic [RegW-1:0] PalLowReset  = 64'h0706050403020100;
  localparam logic [RegW-1:0] PalHighReset = 64'h0F0E0D0C0B0A0908;

  // input commands
  localparam logic CmdLoad = 1'b0;
  localparam logic CmdDraw = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_BASE,
    ST_DRAW,
    ST_REJECT
  } state_t;

  typedef struct packed {
    logic [RegW-1:0] low;
    logic [RegW-1:0] high;
  } pal_t;

  // palette remap of the low sixteen colors
  function automatic logic [ColorW-1:0] remap(input logic [ColorW-1:0] c, input pal_t pal);
    logic [RegW-1:0] sel;
    sel = c[3] ? pal.high : pal.low;
    if (c < ColorW'(RemapLimit)) begin
      return sel[{c[2:0], 3'b000} +: ColorW];
    end
    return c;
  endfunction

endpackage

[rtl/core/ssb_ram.sv]
// ---------------------------------------------------------------------------
// ssb_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ---------------------------------------------------------------------------
module ssb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/core/ssb_apb_regs.sv]
// ---------------------------------------------------------------------------
// ssb_apb_regs
// Configuration registers on the APB-style port: the two palette words.
// ---------------------------------------------------------------------------
module ssb_apb_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ssb_pkg::PaddrW-1:0] paddr,
  input  logic [ssb_pkg::RegW-1:0]   pwdata,
  output logic [ssb_pkg::RegW-1:0]   prdata,
  output logic                       pready,
  output ssb_pkg::pal_t              pal
);
  import ssb_pkg::*;

  logic wr_fire;
  logic reg_idx;

  // register select and write strobe
  assign reg_idx = paddr[RegSel];
  assign wr_fire = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  // palette registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pal.low  <= PalLowReset;
      pal.high <= PalHighReset;
    end else if (wr_fire) begin
      unique case (reg_idx)
        RegPalLow:  pal.low  <= pwdata;
        RegPalHigh: pal.high <= pwdata;
        default:    pal.low  <= pal.low;
      endcase
    end
  end

  // read back
  assign prdata = (reg_idx == RegPalHigh) ? pal.high : pal.low;

endmodule

[rtl/core/sprite_sheet_blitter_top.sv]
// ---------------------------------------------------------------------------
// sprite_sheet_blitter_top
// Tile sprite blitter: sheet store, draw sequencer and result register.
// ---------------------------------------------------------------------------
// A load transfer writes one byte of the 8192-byte sheet memory in its
// accept cycle and gives no result. A draw transfer holds in_stall high
// while the sequencer finds the sheet row of the sprite id, then forms its
// column and the sheet base, then reads one pixel per cycle, while the
// output is not stalled, through the single read port of the sheet memory,
// and until the final pixel leaves the read stage. A rejected id holds
// in_stall high until its one result is taken into the output register.
// Results come one per cycle from an output register; out_stall
// holds the pipeline.
// Sheet bytes that were never loaded read back as whatever the memory holds.
module sprite_sheet_blitter_top #(
  parameter int SCREEN_WIDTH    = ssb_pkg::ScreenWidthDef,
  parameter int SCREEN_HEIGHT   = ssb_pkg::ScreenHeightDef,
  parameter int SPRITE_EDGE     = ssb_pkg::SpriteEdgeDef,
  parameter int SHEET_COLUMNS   = ssb_pkg::SheetColumnsDef,
  parameter int SHEET_ROW_COUNT = ssb_pkg::SheetRowCountDef
) (
  input  logic                         clk,
  input  logic                         rst,
  // input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         cmd,
  input  logic [ssb_pkg::StoreAw-1:0]  sheet_addr,
  input  logic [ssb_pkg::ColorW-1:0]   sheet_byte,
  input  logic [ssb_pkg::IdW-1:0]      sprite_id,
  input  logic signed [ssb_pkg::PosW-1:0] pos_x,
  input  logic signed [ssb_pkg::PosW-1:0] pos_y,
  input  logic                         mirror_x,
  input  logic                         mirror_y,
  // output channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         write_enable,
  output logic [ssb_pkg::PixAddrW-1:0] pixel_addr,
  output logic [ssb_pkg::ColorW-1:0]   pixel_color,
  output logic                         id_rejected,
  output logic                         last,
  // configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ssb_pkg::PaddrW-1:0]   paddr,
  input  logic [ssb_pkg::RegW-1:0]     pwdata,
  output logic [ssb_pkg::RegW-1:0]     prdata,
  output logic                         pready
);
  import ssb_pkg::*;

  localparam int EdgeW   = (SPRITE_EDGE > 1) ? $clog2(SPRITE_EDGE) : 1;
  localparam int XW      = $clog2(SCREEN_WIDTH);
  localparam int YW      = $clog2(SCREEN_HEIGHT);
  localparam int ProdW   = (XW + YW + 1 > PixAddrW) ? XW + YW + 1 : PixAddrW;
  localparam int IdLimit = SHEET_COLUMNS * SHEET_ROW_COUNT;
  // reciprocal for id / SHEET_COLUMNS, exact for 8-bit ids
  localparam int RecipShift = 16;
  localparam int RecipW     = RecipShift + 1;
  localparam int Recip      = ((1 << RecipShift) + SHEET_COLUMNS - 1) / SHEET_COLUMNS;
  localparam int MulW       = IdW + RecipW;
  localparam int BaseW      = 12;
  localparam int AddrTmpW   = 16;

  state_t state, state_next;

  pal_t pal;

  // draw request
  logic [IdW-1:0]        id_q;
  logic signed [PosW-1:0] x0_q, y0_q;
  logic                  fx_q, fy_q;
  logic [IdW-1:0]        row_q;
  logic [IdW-1:0]        col_q;
  logic [BaseW-1:0]      sy_q;

  // issue stage
  logic [EdgeW-1:0]      px, py;
  logic [EdgeW-1:0]      srcx, srcy;
  logic [BaseW-1:0]      sx;
  logic [AddrTmpW-1:0]   row_full;
  logic [StoreAw-1:0]    a_addr;
  logic [CoordW-1:0]     xs, ys;
  logic                  a_on;
  logic [ProdW-1:0]      a_prod;
  logic                  a_last;
  logic [MulW-1:0]       div_prod;

  // read stage
  logic                  b_valid;
  logic [StoreAw-1:0]    b_addr;
  logic                  b_on;
  logic [PixAddrW-1:0]   b_pix;
  logic                  b_last;

  // memory
  logic                  mem_we;
  logic [StoreAw-1:0]    rd_addr;
  logic [ColorW-1:0]     rd_data;

  // handshake and flow
  logic                  in_fire;
  logic                  draw_fire;
  logic                  id_bad;
  logic                  adv_c, adv_b;
  logic                  issue;
  logic                  rej_emit;
  logic                  c_we;

  // configuration registers
  ssb_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .pal     (pal)
  );

  // sheet store
  ssb_ram #(
    .WIDTH (ColorW),
    .DEPTH (StoreDepth)
  ) u_sheet (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (sheet_addr),
    .wr_data (sheet_byte),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // input transfer decode
  assign in_fire   = in_valid && !in_stall;
  assign draw_fire = in_fire && (cmd == CmdDraw);
  assign mem_we    = in_fire && (cmd == CmdLoad);
  assign id_bad    = {{(32 - IdW){1'b0}}, sprite_id} >= 32'(IdLimit);

  // pipeline advance
  assign adv_c = !out_valid || !out_stall;
  assign adv_b = !b_valid || adv_c;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (draw_fire) begin
          state_next = id_bad ? ST_REJECT : ST_DIV;
        end
      end
      ST_DIV:    state_next = ST_BASE;
      ST_BASE:   state_next = ST_DRAW;
      ST_DRAW: begin
        if (issue && a_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_REJECT: begin
        if (adv_c) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall = 1'b1;
    issue    = 1'b0;
    rej_emit = 1'b0;
    unique case (state)
      ST_IDLE:   in_stall = b_valid;
      ST_DIV:    in_stall = 1'b1;
      ST_BASE:   in_stall = 1'b1;
      ST_DRAW:   issue    = adv_b;
      ST_REJECT: rej_emit = 1'b1;
      default:   in_stall = 1'b1;
    endcase
  end

  // sheet row by reciprocal multiply
  assign div_prod = MulW'(id_q) * MulW'(Recip);

  // source pixel with mirroring
  assign srcx = fx_q ? EdgeW'(SPRITE_EDGE - 1) - px : px;
  assign srcy = fy_q ? EdgeW'(SPRITE_EDGE - 1) - py : py;
  assign sx   = BaseW'(col_q) * BaseW'(SPRITE_EDGE);
  assign row_full = AddrTmpW'(sy_q) + AddrTmpW'(srcy);
  assign a_addr   = StoreAw'((row_full << StrideShift) + AddrTmpW'(sx) + AddrTmpW'(srcx));

  // screen position and clipping
  assign xs   = CoordW'(x0_q) + CoordW'(px);
  assign ys   = CoordW'(y0_q) + CoordW'(py);
  assign a_on = !xs[CoordW-1] && (xs < CoordW'(SCREEN_WIDTH)) &&
                !ys[CoordW-1] && (ys < CoordW'(SCREEN_HEIGHT));
  assign a_prod = ProdW'(ys[YW-1:0]) * ProdW'(SCREEN_WIDTH) + ProdW'(xs[XW-1:0]);
  assign a_last = (px == EdgeW'(SPRITE_EDGE - 1)) && (py == EdgeW'(SPRITE_EDGE - 1));

  // read address: next pixel, or the held pixel while the read stage waits
  assign rd_addr = adv_b ? a_addr : b_addr;

  // write decision on the read data
  assign c_we = b_on && (rd_data != '0);

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (adv_b) begin
        b_valid <= issue;
      end
      if (adv_c) begin
        out_valid <= b_valid || rej_emit;
      end
    end
  end

  // draw request and sequencer
  always_ff @(posedge clk) begin
    if (draw_fire) begin
      id_q <= sprite_id;
      x0_q <= pos_x;
      y0_q <= pos_y;
      fx_q <= mirror_x;
      fy_q <= mirror_y;
      px   <= '0;
      py   <= '0;
    end else if (state == ST_DIV) begin
      row_q <= IdW'(div_prod >> RecipShift);
    end else if (state == ST_BASE) begin
      col_q <= id_q - IdW'(BaseW'(row_q) * BaseW'(SHEET_COLUMNS));
      sy_q  <= BaseW'(row_q) * BaseW'(SPRITE_EDGE);
    end else if (issue) begin
      if (px == EdgeW'(SPRITE_EDGE - 1)) begin
        px <= '0;
        py <= py + 1'b1;
      end else begin
        px <= px + 1'b1;
      end
    end
  end

  // read stage payload
  always_ff @(posedge clk) begin
    if (issue) begin
      b_addr <= a_addr;
      b_on   <= a_on;
      b_pix  <= a_prod[PixAddrW-1:0];
      b_last <= a_last;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (adv_c) begin
      if (rej_emit) begin
        write_enable <= 1'b0;
        pixel_addr   <= '0;
        pixel_color  <= '0;
        id_rejected  <= 1'b1;
        last         <= 1'b1;
      end else begin
        write_enable <= c_we;
        pixel_addr   <= c_we ? b_pix : '0;
        pixel_color  <= c_we ? remap(rd_data, pal) : '0;
        id_rejected  <= 1'b0;
        last         <= b_last;
      end
    end
  end

endmodule

[rtl/core/ssb_checker.sv]
// ---------------------------------------------------------------------------
// ssb_checker
// Port-level checks of the sprite sheet blitter, bound to the top level.
// ---------------------------------------------------------------------------
module ssb_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        cmd,
  input logic        out_valid,
  input logic        out_stall,
  input logic        write_enable,
  input logic [13:0] pixel_addr,
  input logic [7:0]  pixel_color,
  input logic        id_rejected,
  input logic        last
);

  // a stalled result transfer keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid &&
      $stable({write_enable, pixel_addr, pixel_color, id_rejected, last}))
    else $error("result changed while stalled");

  // a draw transfer closes the input in the next cycle
  a_draw_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && cmd |=> in_stall)
    else $error("input open right after a draw");

  // a rejected draw is a single, empty, final result
  a_reject: assert property (@(posedge clk) disable iff (rst)
    out_valid && id_rejected |-> last && !write_enable &&
      pixel_addr == 14'd0 && pixel_color == 8'd0)
    else $error("malformed rejected result");

  // pixels not written carry zero address and color
  a_no_write: assert property (@(posedge clk) disable iff (rst)
    out_valid && !write_enable |-> pixel_addr == 14'd0 && pixel_color == 8'd0)
    else $error("unwritten pixel with payload");

endmodule

bind sprite_sheet_blitter_top ssb_checker u_ssb_checker (.*);

[tb/tb_sprite_sheet_blitter_top.sv]
// ---------------------------------------------------------------------------
// tb_sprite_sheet_blitter_top
// Self-checking bench for the sprite sheet blitter. Sprites are loaded byte
// by byte and then drawn at assorted positions and flips, under several
// palette remap settings. A scoreboard keeps its own copy of the sheet and
// palette, predicts every pixel transfer, and compares them in order.
// ---------------------------------------------------------------------------
import ssb_pkg::*;

localparam int SpriteCount  = SheetColumnsDef * SheetRowCountDef;
localparam int PixPerSprite = SpriteEdgeDef * SpriteEdgeDef;

typedef struct packed {
  logic                     cmd;
  logic [StoreAw-1:0]       sheet_addr;
  logic [ColorW-1:0]        sheet_byte;
  logic [IdW-1:0]           sprite_id;
  logic signed [PosW-1:0]   pos_x;
  logic signed [PosW-1:0]   pos_y;
  logic                     mirror_x;
  logic                     mirror_y;
} blit_cmd_t;

typedef struct packed {
  logic                write_enable;
  logic [PixAddrW-1:0] pixel_addr;
  logic [ColorW-1:0]   pixel_color;
  logic                id_rejected;
  logic                last;
} pixel_write_t;

// sheet byte address of one sprite pixel, row-major with 128-byte rows
function automatic logic [StoreAw-1:0] sheet_index(input int id, input int row, input int col);
  int base_x;
  int base_y;
  base_x = (id % SheetColumnsDef) * SpriteEdgeDef;
  base_y = (id / SheetColumnsDef) * SpriteEdgeDef;
  return StoreAw'(((base_y + row) << StrideShift) + base_x + col);
endfunction

// pixel write predictor and in-order checker
class blit_scoreboard;
  logic [ColorW-1:0] sheet [StoreDepth];
  logic [RegW-1:0]   pal_low;
  logic [RegW-1:0]   pal_high;
  pixel_write_t      expected_q[$];
  int                errors;

  function new();
    pal_low  = PalLowReset;
    pal_high = PalHighReset;
    errors   = 0;
  endfunction

  function void set_palette(input logic sel, input logic [RegW-1:0] value);
    if (sel == RegPalHigh) begin
      pal_high = value;
    end else begin
      pal_low = value;
    end
  endfunction

  function logic [ColorW-1:0] remap_color(input logic [ColorW-1:0] c);
    logic [RegW-1:0] pal;
    if (c >= ColorW'(RemapLimit)) begin
      return c;
    end
    pal = c[3] ? pal_high : pal_low;
    return pal[c[2:0] * 8 +: ColorW];
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  function void field_check(input string name, input logic [RegW-1:0] exp_v,
                            input logic [RegW-1:0] got_v);
    if (got_v !== exp_v) begin
      errors++;
      $display("%0t: %s expected %0h actual %0h", $time, name, exp_v, got_v);
    end
  endfunction

  // a load updates the sheet copy, a draw queues its pixel writes
  function void note_input(input blit_cmd_t it);
    pixel_write_t px;
    int src_row;
    int src_col;
    int sx;
    int sy;
    logic [ColorW-1:0] c;
    if (it.cmd == CmdLoad) begin
      sheet[it.sheet_addr] = it.sheet_byte;
      return;
    end
    if (int'(it.sprite_id) >= SpriteCount) begin
      px = '{write_enable: 1'b0, pixel_addr: '0, pixel_color: '0, id_rejected: 1'b1,
             last: 1'b1};
      expected_q.push_back(px);
      return;
    end
    for (int row = 0; row < SpriteEdgeDef; row++) begin
      for (int col = 0; col < SpriteEdgeDef; col++) begin
        src_row = it.mirror_y ? SpriteEdgeDef - 1 - row : row;
        src_col = it.mirror_x ? SpriteEdgeDef - 1 - col : col;
        c  = sheet[sheet_index(it.sprite_id, src_row, src_col)];
        sx = int'($signed(it.pos_x)) + col;
        sy = int'($signed(it.pos_y)) + row;
        px = '0;
        if (c != 0 && sx >= 0 && sx < ScreenWidthDef && sy >= 0 && sy < ScreenHeightDef) begin
          px.write_enable = 1'b1;
          px.pixel_addr   = PixAddrW'(sy * ScreenWidthDef + sx);
          px.pixel_color  = remap_color(c);
        end
        px.last = (row == SpriteEdgeDef - 1) && (col == SpriteEdgeDef - 1);
        expected_q.push_back(px);
      end
    end
  endfunction

  function void check_result(input pixel_write_t got);
    pixel_write_t exp_px;
    if (expected_q.size() == 0) begin
      errors++;
      $display("%0t: unexpected transfer, expected none actual %0h", $time, got);
      return;
    end
    exp_px = expected_q.pop_front();
    field_check("write_enable", exp_px.write_enable, got.write_enable);
    field_check("pixel_addr", exp_px.pixel_addr, got.pixel_addr);
    field_check("pixel_color", exp_px.pixel_color, got.pixel_color);
    field_check("id_rejected", exp_px.id_rejected, got.id_rejected);
    field_check("last", exp_px.last, got.last);
  endfunction
endclass

module tb_sprite_sheet_blitter_top;

  // worst case: under 100 draws, 64 transfers each, every one behind the longest stall
  localparam int CycleLimit   = 2_000_000;
  localparam int SettleCycles = PixPerSprite + 8;
  localparam int ChunkItems   = 18;
  localparam int CmdBits      = $bits(blit_cmd_t);

  logic                   clk;
  logic                   rst;
  logic                   in_valid;
  logic                   in_stall;
  logic                   cmd;
  logic [StoreAw-1:0]     sheet_addr;
  logic [ColorW-1:0]      sheet_byte;
  logic [IdW-1:0]         sprite_id;
  logic signed [PosW-1:0] pos_x;
  logic signed [PosW-1:0] pos_y;
  logic                   mirror_x;
  logic                   mirror_y;
  logic                   out_valid;
  logic                   out_stall;
  logic                   write_enable;
  logic [PixAddrW-1:0]    pixel_addr;
  logic [ColorW-1:0]      pixel_color;
  logic                   id_rejected;
  logic                   last;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [PaddrW-1:0]      paddr;
  logic [RegW-1:0]        pwdata;
  logic [RegW-1:0]        prdata;
  logic                   pready;

  blit_scoreboard sb;
  bit             sheet_written [StoreDepth];
  int             cycle_count;
  int             calm_left;
  int             fill_budget;

  sprite_sheet_blitter_top DUT (.*);

  // clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // check every pixel transfer
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check_result('{write_enable: write_enable, pixel_addr: pixel_addr,
                        pixel_color: pixel_color, id_rejected: id_rejected, last: last});
    end
  end

  // output stall: free runs, mostly short stalls, now and then a long one
  initial begin
    int  run;
    bit  stalling;
    stalling  = 1'b0;
    out_stall = 1'b0;
    forever begin
      if (stalling) begin
        run = $urandom_range(0, 99);
        run = (run < 75) ? $urandom_range(1, 2) :
              (run < 95) ? $urandom_range(3, 8) : $urandom_range(15, 25);
      end else begin
        run = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 10) : $urandom_range(20, 80);
      end
      out_stall = stalling;
      repeat (run) @(negedge clk);
      stalling = !stalling;
    end
  end

  // input gap length, with calm stretches of back-to-back transfers
  function automatic int pick_gap();
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      calm_left = $urandom_range(10, 40);
      return 0;
    end
    return (r < 55) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(6, 30);
  endfunction

  function automatic logic [ColorW-1:0] pick_color();
    int r;
    r = $urandom_range(0, 9);
    return (r < 3) ? ColorW'(0) : (r < 7) ? ColorW'($urandom_range(1, 15)) :
           ColorW'($urandom_range(16, 255));
  endfunction

  function automatic logic signed [PosW-1:0] pick_pos();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return PosW'($urandom_range(0, ScreenWidthDef - SpriteEdgeDef));
    if (r < 8) begin
      return $urandom_range(0, 1) ? PosW'(-int'($urandom_range(1, SpriteEdgeDef - 1))) :
                                    PosW'($urandom_range(ScreenWidthDef - SpriteEdgeDef + 1,
                                                         ScreenWidthDef));
    end
    return PosW'($urandom);
  endfunction

  // draw fields are junk on a load, and load fields junk on a draw
  function automatic blit_cmd_t load_cmd(input int addr, input int value);
    blit_cmd_t it;
    it            = blit_cmd_t'(CmdBits'({$urandom, $urandom}));
    it.cmd        = CmdLoad;
    it.sheet_addr = StoreAw'(addr);
    it.sheet_byte = ColorW'(value);
    return it;
  endfunction

  function automatic blit_cmd_t draw_cmd(input int id, input int x, input int y,
                                         input bit mx, input bit my);
    blit_cmd_t it;
    it           = blit_cmd_t'(CmdBits'({$urandom, $urandom}));
    it.cmd       = CmdDraw;
    it.sprite_id = IdW'(id);
    it.pos_x     = PosW'(x);
    it.pos_y     = PosW'(y);
    it.mirror_x  = mx;
    it.mirror_y  = my;
    return it;
  endfunction

  function automatic bit sprite_ready(input int id);
    for (int row = 0; row < SpriteEdgeDef; row++) begin
      for (int col = 0; col < SpriteEdgeDef; col++) begin
        if (!sheet_written[sheet_index(id, row, col)]) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  // one input transfer; called at a falling edge, returns at one
  task automatic send_item(input blit_cmd_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   = 1'b1;
    cmd        = it.cmd;
    sheet_addr = it.sheet_addr;
    sheet_byte = it.sheet_byte;
    sprite_id  = it.sprite_id;
    pos_x      = it.pos_x;
    pos_y      = it.pos_y;
    mirror_x   = it.mirror_x;
    mirror_y   = it.mirror_y;
    do @(posedge clk); while (in_stall);
    sb.note_input(it);
    if (it.cmd == CmdLoad) sheet_written[it.sheet_addr] = 1'b1;
    @(negedge clk);
  endtask

  task automatic fill_sprite(input int id);
    for (int row = 0; row < SpriteEdgeDef; row++) begin
      for (int col = 0; col < SpriteEdgeDef; col++) begin
        send_item(load_cmd(sheet_index(id, row, col), pick_color()));
      end
    end
  endtask

  task automatic apb_xfer(input logic wr, input logic [PaddrW-1:0] addr,
                          input logic [RegW-1:0] wdata, output logic [RegW-1:0] rdata);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = addr;
    pwdata  = wdata;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // registers sit at an 8-byte stride
  task automatic write_palette(input logic sel, input logic [RegW-1:0] value);
    logic [RegW-1:0] rd;
    apb_xfer(1'b1, PaddrW'({sel, 3'b000}), value, rd);
    apb_xfer(1'b0, PaddrW'({sel, 3'b000}), '0, rd);
    sb.field_check("palette readback", value, rd);
    sb.set_palette(sel, value);
  endtask

  // wait for all pixel transfers, then let the block go quiet
  task automatic settle();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  // mixed traffic: draws of loaded sprites, rejects, stray loads, new sprites
  task automatic run_mixed(input int count);
    int pick;
    int id;
    int ids[$];
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      ids.delete();
      for (int s = 0; s < SpriteCount; s++) begin
        if (sprite_ready(s)) ids.push_back(s);
      end
      if (fill_budget > 0 && (ids.size() < 3 || pick < 3) && ids.size() < SpriteCount) begin
        fill_budget--;
        id = $urandom_range(0, SpriteCount - 1);
        while (sprite_ready(id)) id = (id + 1) % SpriteCount;
        fill_sprite(id);
      end else if (pick < 58) begin
        send_item(draw_cmd(ids[$urandom_range(0, ids.size() - 1)], pick_pos(), pick_pos(),
                           $urandom_range(0, 1), $urandom_range(0, 1)));
      end else if (pick < 68) begin
        send_item(draw_cmd($urandom_range(SpriteCount, 255), pick_pos(), pick_pos(),
                           $urandom_range(0, 1), $urandom_range(0, 1)));
      end else if (pick < 84) begin
        id = ids[$urandom_range(0, ids.size() - 1)];
        send_item(load_cmd(sheet_index(id, $urandom_range(0, SpriteEdgeDef - 1),
                                       $urandom_range(0, SpriteEdgeDef - 1)), pick_color()));
      end else begin
        send_item(load_cmd($urandom_range(0, StoreDepth - 1), $urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    logic [RegW-1:0] rd;
    logic [RegW-1:0] pal;
    sb          = new();
    cycle_count = 0;
    calm_left   = 0;
    fill_budget = 0;
    rst         = 1'b1;
    in_valid    = 1'b0;
    cmd         = CmdLoad;
    sheet_addr  = '0;
    sheet_byte  = '0;
    sprite_id   = '0;
    pos_x       = '0;
    pos_y       = '0;
    mirror_x    = 1'b0;
    mirror_y    = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset values of the palette
    apb_xfer(1'b0, PaddrW'({RegPalLow, 3'b000}), '0, rd);
    sb.field_check("pal_remap_low reset", PalLowReset, rd);
    apb_xfer(1'b0, PaddrW'({RegPalHigh, 3'b000}), '0, rd);
    sb.field_check("pal_remap_high reset", PalHighReset, rd);

    // first and last sprite of the sheet, then extreme bytes at the store ends
    fill_sprite(0);
    fill_sprite(SpriteCount - 1);
    send_item(load_cmd(0, 255));
    send_item(load_cmd(StoreDepth - 1, 0));
    send_item(load_cmd(StoreDepth - 2, 15));
    send_item(load_cmd(1, 16));

    // every flip, clipping on each side, fully off screen, far corner
    send_item(draw_cmd(0, 0, 0, 1'b0, 1'b0));
    send_item(draw_cmd(0, 10, 20, 1'b1, 1'b0));
    send_item(draw_cmd(0, 10, 20, 1'b0, 1'b1));
    send_item(draw_cmd(0, 10, 20, 1'b1, 1'b1));
    send_item(draw_cmd(SpriteCount - 1, 120, 120, 1'b0, 1'b0));
    send_item(draw_cmd(SpriteCount - 1, -4, -4, 1'b1, 1'b0));
    send_item(draw_cmd(0, 124, 3, 1'b0, 1'b1));
    send_item(draw_cmd(SpriteCount - 1, -1, 127, 1'b1, 1'b1));
    send_item(draw_cmd(0, -8, 0, 1'b0, 1'b0));
    send_item(draw_cmd(0, 128, 0, 1'b0, 1'b0));
    send_item(draw_cmd(0, 0, -8, 1'b0, 1'b0));
    send_item(draw_cmd(0, -256, -256, 1'b1, 1'b1));
    send_item(draw_cmd(SpriteCount - 1, 255, 255, 1'b0, 1'b0));
    // out-of-range ids give a single rejected transfer
    send_item(draw_cmd(SpriteCount, -256, 255, 1'b1, 1'b0));
    send_item(draw_cmd(255, 255, -256, 1'b0, 1'b1));

    run_mixed(ChunkItems);

    // every low color remaps to zero but is still written
    settle();
    write_palette(RegPalLow, '0);
    write_palette(RegPalHigh, '0);
    run_mixed(ChunkItems);

    settle();
    write_palette(RegPalLow, '1);
    write_palette(RegPalHigh, '1);
    run_mixed(ChunkItems);

    // random palette with one zero entry in each half
    settle();
    pal = {$urandom, $urandom};
    pal[$urandom_range(0, 7) * 8 +: ColorW] = '0;
    write_palette(RegPalLow, pal);
    pal = {$urandom, $urandom};
    pal[$urandom_range(0, 7) * 8 +: ColorW] = '0;
    write_palette(RegPalHigh, pal);
    run_mixed(ChunkItems);

    settle();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
